[sv/frp_pkg.sv]
// Shared types and constants of the frame rate pacer.
// No dependencies; every other file of the block imports this package.
package frp_pkg;

  localparam int WIN_DEPTH   = 256;
  localparam int WIN_AW      = $clog2(WIN_DEPTH);
  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 32;

  // Register indexes (byte address divided by four).
  localparam logic [1:0] REG_FPS    = 2'd0;
  localparam logic [1:0] REG_WHOLE  = 2'd1;
  localparam logic [1:0] REG_FRAC   = 2'd2;
  localparam logic [1:0] REG_LINKED = 2'd3;

  localparam logic [7:0]  FPS_RST    = 8'd60;
  localparam logic [9:0]  WHOLE_RST  = 10'd16;
  localparam logic [15:0] FRAC_RST   = 16'd43690;
  localparam logic        LINKED_RST = 1'b1;

  typedef struct packed {
    logic [7:0]  fps;
    logic [9:0]  whole;
    logic [15:0] frac;
    logic        linked;
  } frp_cfg_t;

  typedef struct packed {
    logic        render;
    logic [9:0]  delay;
    logic        skipped;
    logic [15:0] interval;
    logic [15:0] step;
    logic [15:0] updates;
  } frp_tick_t;

  function automatic logic [15:0] sat16(input logic [63:0] v);
    return (|v[63:16]) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

[sv/frame_rate_pacer.sv]
// Top level of the frame rate pacer: input register, timer, window, result register.
// Depends on frp_pkg, frp_cfg, frp_timer and frp_window.
//
// The pacer takes one millisecond time sample per request and returns exactly
// one result request for it. It keeps the next frame deadline, advancing it by
// the whole-millisecond period plus the carry of a 16-bit fraction accumulator.
// In linked mode every tick is a frame and the result carries the delay still
// owed until the deadline (saturating at 1023 ms) and a skip flag when none is
// owed. In unlinked mode a tick before the deadline is no frame, and a tick more
// than two periods past the deadline is dropped. Each frame pushes its interval
// into a moving window of frames_per_second entries whose sum and fill are
// reported, and the block counts ticks between renders. A request is taken
// into the input register, and all its work is done combinationally on the way
// to the result register, so a new request is accepted every clock cycle while
// the output does not stall; out_valid rises when the result register is loaded.
// The loop through the deadline adder and the window sum sets that rate. The
// input side stalls only when both the input register and the result register
// are full and the output is stalled. Any configuration write empties the
// window and re-arms the timer, so the next tick sets the deadline from its own
// time and is then handled as any other; writes are meant to be made while the
// block holds no request.
module frame_rate_pacer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [63:0]                in_now_ms,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_render_step,
  output logic [9:0]                 out_delay_ms,
  output logic                       out_frame_skipped,
  output logic [15:0]                out_frame_interval,
  output logic [23:0]                out_window_total,
  output logic [7:0]                 out_window_entries,
  output logic [15:0]                out_step_time,
  output logic [15:0]                out_update_count,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [frp_pkg::CFG_AW-1:0] paddr,
  input  logic [frp_pkg::CFG_DW-1:0] pwdata,
  output logic [frp_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import frp_pkg::*;

  frp_cfg_t  cfg;
  logic      cfg_clear;
  frp_tick_t tick;
  logic [23:0] total_nxt;
  logic [7:0]  entries_nxt;

  // Input register.
  logic        s1_v_r;
  logic [63:0] s1_now_r;
  // Result register.
  logic        out_v_r;
  frp_tick_t   out_tick_r;
  logic [23:0] out_total_r;
  logic [7:0]  out_entries_r;

  logic out_load;
  logic in_take;

  // The held request moves on whenever the result register is empty or drains.
  assign out_load = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall = s1_v_r && !out_load;
  assign in_take  = in_valid && !in_stall;

  frp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg       (cfg),
    .cfg_clear (cfg_clear)
  );

  frp_timer u_timer (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cfg_clear (cfg_clear),
    .load      (out_load),
    .now       (s1_now_r),
    .tick      (tick)
  );

  frp_window u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .fps         (cfg.fps),
    .clear       (cfg_clear),
    .push        (out_load && tick.render),
    .interval    (tick.interval),
    .total_nxt   (total_nxt),
    .entries_nxt (entries_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_v_r <= 1'b1;
      end else if (out_load) begin
        s1_v_r <= 1'b0;
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_now_r <= in_now_ms;
    end
    if (out_load) begin
      out_tick_r    <= tick;
      out_total_r   <= total_nxt;
      out_entries_r <= entries_nxt;
    end
  end

  assign out_valid          = out_v_r;
  assign out_render_step    = out_tick_r.render;
  assign out_delay_ms       = out_tick_r.delay;
  assign out_frame_skipped  = out_tick_r.skipped;
  assign out_frame_interval = out_tick_r.interval;
  assign out_window_total   = out_total_r;
  assign out_window_entries = out_entries_r;
  assign out_step_time      = out_tick_r.step;
  assign out_update_count   = out_tick_r.updates;

  a_load_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_v_r)
    else $error("processed request produced no result");

  a_held_request_kept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !out_load |=> s1_v_r && $stable(s1_now_r))
    else $error("held request lost or changed");

endmodule

[sv/frp_cfg.sv]
// Configuration register file of the frame rate pacer, on an APB-style port.
// Depends on frp_pkg.
module frp_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [frp_pkg::CFG_AW-1:0] paddr,
  input  logic [frp_pkg::CFG_DW-1:0] pwdata,
  output logic [frp_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output frp_pkg::frp_cfg_t          cfg,
  output logic                       cfg_clear
);
  import frp_pkg::*;

  frp_cfg_t   cfg_r;
  logic       wr_en;
  logic [1:0] idx;

  assign idx       = paddr[3:2];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;
  assign cfg       = cfg_r;
  // Every write, to any register, empties the window and re-arms the timer.
  assign cfg_clear = wr_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fps    <= FPS_RST;
      cfg_r.whole  <= WHOLE_RST;
      cfg_r.frac   <= FRAC_RST;
      cfg_r.linked <= LINKED_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_FPS:    cfg_r.fps    <= pwdata[7:0];
        REG_WHOLE:  cfg_r.whole  <= pwdata[9:0];
        REG_FRAC:   cfg_r.frac   <= pwdata[15:0];
        REG_LINKED: cfg_r.linked <= pwdata[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FPS:    prdata = {24'd0, cfg_r.fps};
      REG_WHOLE:  prdata = {22'd0, cfg_r.whole};
      REG_FRAC:   prdata = {16'd0, cfg_r.frac};
      REG_LINKED: prdata = {31'd0, cfg_r.linked};
      default:    prdata = '0;
    endcase
  end

endmodule

[sv/frp_timer.sv]
// Deadline keeping, frame decision and tick counters of the frame rate pacer.
// Depends on frp_pkg.
module frp_timer (
  input  logic              clk,
  input  logic              rst_n,
  input  frp_pkg::frp_cfg_t cfg,
  input  logic              cfg_clear,
  input  logic              load,
  input  logic [63:0]       now,
  output frp_pkg::frp_tick_t tick
);
  import frp_pkg::*;

  logic        armed_r;
  logic [63:0] deadline_r;
  logic [16:0] acc_r;
  logic [63:0] last_frame_r;
  logic [63:0] last_tick_r;
  logic        last_render_r;
  logic [15:0] updates_r;

  logic        before_dl;
  logic [63:0] ahead;
  logic [63:0] behind;
  logic [64:0] arm_sum;
  logic [9:0]  delay_raw;
  logic [27:0] late_lim;
  logic        late;
  logic        advance;
  logic        render;
  logic [16:0] acc_eff;
  logic [16:0] acc_nxt;
  logic [10:0] dl_add;
  logic [63:0] dl_base;
  logic [63:0] deadline_nxt;
  logic        dl_load;
  logic [15:0] updates_nxt;

  assign ahead    = deadline_r - now;
  assign behind   = now - deadline_r;
  // The arming deadline; its top bit is set when it wraps past the time range.
  assign arm_sum  = {1'b0, now} + {55'd0, cfg.whole};
  // Twice the period in 1/65536 ms; below 2^28 for every register value.
  assign late_lim = {1'b0, ({cfg.whole, 16'd0} + {10'd0, cfg.frac}), 1'b0};
  assign acc_eff  = armed_r ? acc_r : 17'd0;
  assign acc_nxt  = {1'b0, acc_eff[15:0]} + {1'b0, cfg.frac};
  assign dl_base  = armed_r ? deadline_r : now;

  always_comb begin
    // An unarmed tick behaves as if the deadline were now plus the whole period.
    // When that sum wraps, the deadline lies far behind the tick, which is then
    // past it and far too late.
    if (armed_r) begin
      before_dl = now < deadline_r;
      delay_raw = (|ahead[63:10]) ? 10'h3FF : ahead[9:0];
      late      = (|behind[63:12]) || ({behind[11:0], 16'd0} > late_lim);
    end else begin
      before_dl = (cfg.whole != 10'd0) && !arm_sum[64];
      delay_raw = cfg.whole;
      late      = arm_sum[64];
    end

    tick.delay   = '0;
    tick.skipped = 1'b0;
    if (cfg.linked) begin
      advance      = 1'b1;
      render       = 1'b1;
      tick.delay   = before_dl ? delay_raw : 10'd0;
      tick.skipped = !before_dl;
    end else begin
      advance = !before_dl;
      render  = !before_dl && !late;
    end

    if (advance) begin
      dl_add = armed_r ? ({1'b0, cfg.whole} + {10'd0, acc_r[16]})
                       : {cfg.whole, 1'b0};
    end else begin
      dl_add = {1'b0, cfg.whole};
    end
    deadline_nxt = dl_base + {53'd0, dl_add};
    dl_load      = advance || !armed_r;

    tick.render   = render;
    tick.step     = armed_r ? sat16(now - last_tick_r) : 16'd0;
    tick.interval = (render && armed_r) ? sat16(now - last_frame_r) : 16'd0;

    if (last_render_r) begin
      updates_nxt = 16'd0;
    end else begin
      updates_nxt = (updates_r == 16'hFFFF) ? updates_r : updates_r + 16'd1;
    end
    tick.updates = updates_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r       <= 1'b0;
      deadline_r    <= '0;
      acc_r         <= '0;
      last_frame_r  <= '0;
      last_tick_r   <= '0;
      last_render_r <= 1'b0;
      updates_r     <= '0;
    end else if (cfg_clear) begin
      armed_r <= 1'b0;
    end else if (load) begin
      armed_r       <= 1'b1;
      last_tick_r   <= now;
      last_render_r <= render;
      updates_r     <= updates_nxt;
      if (dl_load) begin
        deadline_r <= deadline_nxt;
      end
      if (advance) begin
        acc_r <= acc_nxt;
      end else if (!armed_r) begin
        acc_r <= '0;
      end
      // Arming also starts the frame interval from this tick.
      if (render || !armed_r) begin
        last_frame_r <= now;
      end
    end
  end

  a_linked_renders: assert property (@(posedge clk) disable iff (!rst_n)
    load && cfg.linked |-> tick.render)
    else $error("linked tick did not render");

  a_arms_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    load && !cfg_clear |=> armed_r)
    else $error("timer not armed after a tick");

  a_no_delay_unlinked: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg.linked |-> tick.delay == 10'd0 && !tick.skipped)
    else $error("delay reported in unlinked mode");

endmodule

[sv/frp_window.sv]
// Moving window of frame intervals with its running sum for the frame rate pacer.
// Depends on frp_pkg; holds the interval memory.
module frp_window (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  fps,
  input  logic        clear,
  input  logic        push,
  input  logic [15:0] interval,
  output logic [23:0] total_nxt,
  output logic [7:0]  entries_nxt
);
  import frp_pkg::*;

  logic [15:0]       mem [WIN_DEPTH];
  logic [15:0]       oldest_val_r;   // always holds mem[oldest_r]

  logic [WIN_AW:0]   count_r;
  logic [23:0]       sum_r;
  logic [WIN_AW-1:0] oldest_r;

  logic [WIN_AW:0]   count_nxt;
  logic [WIN_AW-1:0] oldest_nxt;
  logic [WIN_AW:0]   count1;
  logic [23:0]       sum1;
  logic              full;
  logic              we;
  logic [WIN_AW-1:0] waddr;

  assign full = count_r >= {1'b0, fps};

  always_comb begin
    count_nxt  = count_r;
    total_nxt  = sum_r;
    oldest_nxt = oldest_r;
    count1     = count_r;
    sum1       = sum_r;
    we         = 1'b0;
    waddr      = '0;
    if (clear || (push && fps == 8'd0)) begin
      count_nxt  = '0;
      total_nxt  = '0;
      oldest_nxt = '0;
    end else if (push) begin
      if (full) begin
        oldest_nxt = oldest_r + 1'b1;
        count1     = count_r - 1'b1;
        sum1       = sum_r - {8'd0, oldest_val_r};
      end
      waddr     = oldest_nxt + count1[WIN_AW-1:0];
      we        = 1'b1;
      count_nxt = count1 + 1'b1;
      total_nxt = sum1 + {8'd0, interval};
    end
    entries_nxt = count_nxt[7:0];
  end

  // The read port fetches the entry that will be oldest after this cycle, with
  // the write forwarded when both hit the same slot.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= interval;
    end
    if (we && waddr == oldest_nxt) begin
      oldest_val_r <= interval;
    end else begin
      oldest_val_r <= mem[oldest_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      sum_r    <= '0;
      oldest_r <= '0;
    end else begin
      count_r  <= count_nxt;
      sum_r    <= total_nxt;
      oldest_r <= oldest_nxt;
    end
  end

  a_count_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= {1'b0, fps})
    else $error("window holds more entries than the frame rate");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !push && !clear |=> $stable(count_r) && $stable(sum_r) && $stable(oldest_r))
    else $error("window changed without a push");

endmodule

[tb/frp_tb_pkg.sv]
// Test types and the frame pacing tracker used by the frame rate pacer bench.
// Depends on frp_pkg for the register indexes, reset values and window depth.
package frp_tb_pkg;

  typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_style_t;
  typedef enum int {TICK_STEADY, TICK_JITTER, TICK_BURST, TICK_SLOW, TICK_NOISE} tick_style_t;

  typedef struct packed {
    bit        render;
    bit [9:0]  delay;
    bit        skipped;
    bit [15:0] interval;
    bit [23:0] total;
    bit [7:0]  entries;
    bit [15:0] step;
    bit [15:0] updates;
  } pace_result_t;

  // Shadow copy of the pacer: registers, timer, interval window and the
  // queue of results owed by the block for requests it has taken.
  class frame_pace_tracker;
    bit [7:0]                 fps;
    bit [9:0]                 whole;
    bit [15:0]                frac;
    bit                       linked;
    bit                       armed;
    bit [63:0]                deadline;
    bit [16:0]                frac_acc;
    bit [63:0]                last_frame_ms;
    bit [63:0]                last_tick_ms;
    bit [15:0]                intervals [frp_pkg::WIN_DEPTH];
    bit [frp_pkg::WIN_AW-1:0] oldest;
    bit [8:0]                 held;
    bit [23:0]                held_sum;
    bit                       prev_render;
    bit [15:0]                updates;
    pace_result_t             owed_results[$];
    int                       mismatches;
    int                       checked;
    int                       frames;
    int                       skips;
    int                       drops;
    int                       writes;

    function new();
      fps    = frp_pkg::FPS_RST;
      whole  = frp_pkg::WHOLE_RST;
      frac   = frp_pkg::FRAC_RST;
      linked = frp_pkg::LINKED_RST;
    endfunction

    task flag(input string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    function bit [31:0] reg_value(input logic [1:0] idx);
      case (idx)
        frp_pkg::REG_FPS:    return 32'(fps);
        frp_pkg::REG_WHOLE:  return 32'(whole);
        frp_pkg::REG_FRAC:   return 32'(frac);
        frp_pkg::REG_LINKED: return 32'(linked);
        default:             return 32'd0;
      endcase
    endfunction

    // Any register write empties the window and re-arms the timer.
    function void set_reg(input logic [1:0] idx, input logic [31:0] v);
      case (idx)
        frp_pkg::REG_FPS:    fps = v[7:0];
        frp_pkg::REG_WHOLE:  whole = v[9:0];
        frp_pkg::REG_FRAC:   frac = v[15:0];
        frp_pkg::REG_LINKED: linked = v[0];
        default: ;
      endcase
      held     = '0;
      held_sum = '0;
      oldest   = '0;
      armed    = 1'b0;
      writes++;
    endfunction

    function bit [15:0] clip16(input bit [63:0] v);
      return (v > 64'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    function void step_deadline();
      deadline = deadline + 64'(whole) + 64'(frac_acc[16]);
      frac_acc = 17'(frac_acc[15:0]) + 17'(frac);
    endfunction

    function void push_interval(input bit [15:0] v);
      bit [frp_pkg::WIN_AW-1:0] slot;
      if (fps == 8'd0) begin
        held     = '0;
        held_sum = '0;
        oldest   = '0;
        return;
      end
      while (held >= 9'(fps)) begin
        held_sum = held_sum - 24'(intervals[oldest]);
        oldest++;
        held--;
      end
      slot            = oldest + held[7:0];
      intervals[slot] = v;
      held++;
      held_sum = held_sum + 24'(v);
    endfunction

    // Works out the result of one accepted time sample.
    function void take_tick(input bit [63:0] now);
      pace_result_t r;
      bit [63:0]    d;
      bit [63:0]    dif;
      bit [63:0]    limit_fx;
      bit           render;
      bit           late;
      r      = '0;
      render = 1'b0;
      if (!armed) begin
        deadline      = now + 64'(whole);
        frac_acc      = '0;
        last_frame_ms = now;
        last_tick_ms  = now;
        armed         = 1'b1;
      end
      r.step       = clip16(now - last_tick_ms);
      last_tick_ms = now;
      if (linked) begin
        if (now < deadline) begin
          d       = deadline - now;
          r.delay = (d > 64'd1023) ? 10'd1023 : d[9:0];
        end
        step_deadline();
        r.skipped = (r.delay == 10'd0);
        render    = 1'b1;
        if (r.skipped) skips++;
      end else if (now >= deadline) begin
        dif      = now - deadline;
        limit_fx = 64'd2 * ((64'(whole) << 16) + 64'(frac));
        late     = (dif[63:40] != '0) || ((dif << 16) > limit_fx);
        step_deadline();
        render = !late;
        if (late) drops++;
      end
      if (render) begin
        r.interval    = clip16(now - last_frame_ms);
        push_interval(r.interval);
        last_frame_ms = now;
        frames++;
      end
      if (prev_render) updates = '0;
      else if (updates != 16'hFFFF) updates++;
      prev_render = render;
      r.render    = render;
      r.total     = held_sum;
      r.entries   = held[7:0];
      r.updates   = updates;
      owed_results.push_back(r);
    endfunction

    task compare_field(input string name, input bit [63:0] got, input bit [63:0] want);
      if (got != want)
        flag($sformatf("result %0d %s: got %0d, expected %0d", checked, name, got, want));
    endtask

    task match_result(input pace_result_t got);
      pace_result_t want;
      if (owed_results.size() == 0) begin
        flag("result arrived with no request waiting for it");
        return;
      end
      want = owed_results.pop_front();
      compare_field("render_step", got.render, want.render);
      compare_field("delay_ms", got.delay, want.delay);
      compare_field("frame_skipped", got.skipped, want.skipped);
      compare_field("frame_interval", got.interval, want.interval);
      compare_field("window_total", got.total, want.total);
      compare_field("window_entries", got.entries, want.entries);
      compare_field("step_time", got.step, want.step);
      compare_field("update_count", got.updates, want.updates);
      checked++;
    endtask
  endclass

endpackage

[tb/tb_frame_rate_pacer.sv]
// Self-checking bench for frame_rate_pacer: directed and random time samples.
// Depends on frp_pkg and frp_tb_pkg (frame pacing tracker and test types).
module tb_frame_rate_pacer;
  import frp_tb_pkg::*;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [63:0]                in_now_ms = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       out_render_step;
  logic [9:0]                 out_delay_ms;
  logic                       out_frame_skipped;
  logic [15:0]                out_frame_interval;
  logic [23:0]                out_window_total;
  logic [7:0]                 out_window_entries;
  logic [15:0]                out_step_time;
  logic [15:0]                out_update_count;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [frp_pkg::CFG_AW-1:0] paddr = '0;
  logic [frp_pkg::CFG_DW-1:0] pwdata = '0;
  logic [frp_pkg::CFG_DW-1:0] prdata;
  logic                       pready;

  frame_pace_tracker pace = new();
  idle_style_t       in_idle = IDLE_SPARSE;
  idle_style_t       out_idle = IDLE_SPARSE;
  bit [63:0]         clock_ms;
  int                ticks_sent;

  frame_rate_pacer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_now_ms          (in_now_ms),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_render_step    (out_render_step),
    .out_delay_ms       (out_delay_ms),
    .out_frame_skipped  (out_frame_skipped),
    .out_frame_interval (out_frame_interval),
    .out_window_total   (out_window_total),
    .out_window_entries (out_window_entries),
    .out_step_time      (out_step_time),
    .out_update_count   (out_update_count),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // A hard stop well beyond the slowest legal run.
  initial begin
    #12_000_000;
    $display("FAIL frame_rate_pacer");
    $finish;
  end

  // Number of cycles a side holds off before its next request. The sparse
  // style idles only now and then, so long unbroken runs still occur.
  function automatic int idle_draw(input idle_style_t style);
    case (style)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, 13);
      default:   return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 13) : 0;
    endcase
  endfunction

  // Result side: before each result the stall is held high for a drawn number
  // of cycles, then dropped until a result has been taken. All sampling is done
  // at the rising edge, so the values seen are those the block itself saw.
  initial begin
    int hold;
    wait (rst_n);
    forever begin
      hold = idle_draw(out_idle);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Every result taken is matched against the oldest owed one.
  always @(posedge clk) begin : watch_results
    pace_result_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen.render   = out_render_step;
      seen.delay    = out_delay_ms;
      seen.skipped  = out_frame_skipped;
      seen.interval = out_frame_interval;
      seen.total    = out_window_total;
      seen.entries  = out_window_entries;
      seen.step     = out_step_time;
      seen.updates  = out_update_count;
      pace.match_result(seen);
    end
  end

  // Offers one time sample after a drawn gap and returns at the edge where the
  // block takes it; the tracker predicts its result at that moment. Valid is
  // left high so back-to-back requests need no toggle.
  task automatic send_tick(input bit [63:0] now);
    int gap;
    gap = idle_draw(in_idle);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_now_ms <= now;
    do @(posedge clk); while (in_stall);
    pace.take_tick(now);
    ticks_sent++;
  endtask

  // Stops sending and waits until every owed result has come back, then
  // allows the input and result registers a little extra time to fall quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (pace.owed_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // APB read of one register, compared with the tracker's copy. The data is
  // taken at the access edge where pready is high.
  task automatic read_check(input logic [1:0] idx);
    logic [31:0] got;
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got     = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got !== pace.reg_value(idx))
      pace.flag($sformatf("register %0d reads %0h, expected %0h", idx, got,
                          pace.reg_value(idx)));
  endtask

  // APB write: setup cycle then access cycle; an idle cycle follows so that
  // the next transfer never reassigns psel in the same step.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    pace.set_reg(idx, value);
    read_check(idx);
  endtask

  // Picks new settings, favouring the extremes: window of one, the longest
  // window, small windows that wrap often, and an empty window at rate zero.
  task automatic write_random_config(input bit every);
    int sel;
    if (every || $urandom_range(0, 1)) begin
      sel = $urandom_range(0, 11);
      if (sel == 0) write_reg(frp_pkg::REG_FPS, 32'd0);
      else if (sel < 3) write_reg(frp_pkg::REG_FPS, 32'd1);
      else if (sel < 5) write_reg(frp_pkg::REG_FPS, 32'd255);
      else if (sel < 9) write_reg(frp_pkg::REG_FPS, $urandom_range(1, 8));
      else write_reg(frp_pkg::REG_FPS, $urandom_range(1, 255));
    end
    if (every || $urandom_range(0, 1)) begin
      sel = $urandom_range(0, 7);
      if (sel == 0) write_reg(frp_pkg::REG_WHOLE, 32'd0);
      else if (sel == 1) write_reg(frp_pkg::REG_WHOLE, 32'd1000);
      else if (sel < 6) write_reg(frp_pkg::REG_WHOLE, $urandom_range(1, 40));
      else write_reg(frp_pkg::REG_WHOLE, $urandom_range(0, 1000));
    end
    if (every || $urandom_range(0, 1)) begin
      sel = $urandom_range(0, 5);
      if (sel == 0) write_reg(frp_pkg::REG_FRAC, 32'd0);
      else if (sel == 1) write_reg(frp_pkg::REG_FRAC, 32'd65535);
      else write_reg(frp_pkg::REG_FRAC, $urandom_range(0, 65535));
    end
    if (every || $urandom_range(0, 1))
      write_reg(frp_pkg::REG_LINKED, $urandom_range(0, 1));
  endtask

  // Runs a stretch of time samples. Steady steps sit around the period so the
  // gated mode gets real frames; noise jumps anywhere, including backwards.
  // Now and then the sender waits for the block to drain completely.
  task automatic run_ticks(input tick_style_t style, input int count);
    for (int i = 0; i < count; i++) begin
      case (style)
        TICK_STEADY: clock_ms = clock_ms + pace.whole + $urandom_range(0, 4) - 64'd2;
        TICK_JITTER: clock_ms = clock_ms + $urandom_range(0, 3 * pace.whole + 12);
        TICK_BURST:  clock_ms = clock_ms + $urandom_range(0, 2);
        TICK_SLOW:   clock_ms = clock_ms + $urandom_range(60000, 80000);
        default: begin
          case ($urandom_range(0, 3))
            0:       clock_ms = {$urandom, $urandom};
            1:       clock_ms = clock_ms - $urandom_range(1, 5000);
            2:       clock_ms = clock_ms + $urandom_range(0, 200000);
            default: clock_ms = clock_ms + $urandom;
          endcase
        end
      endcase
      if ($urandom_range(0, 39) == 0) settle();
      send_tick(clock_ms);
    end
  endtask

  initial begin
    int          sel;
    tick_style_t style;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values of all four registers.
    for (int r = 0; r < 4; r++) read_check(r[1:0]);

    // Linked mode at reset settings: arming tick, a delay owed, a late tick
    // that is skipped, a repeated time, the largest time, a step back through
    // zero and a long gap that saturates the step and interval.
    send_tick(64'd1000);
    send_tick(64'd1010);
    send_tick(64'd1100);
    send_tick(64'd1100);
    send_tick(64'hFFFF_FFFF_FFFF_FFFF);
    send_tick(64'd0);
    send_tick(64'd70000);
    settle();

    // A period of 1000 ms; going back in time leaves a delay beyond 1023 ms,
    // which must saturate. Alternating bit patterns follow.
    write_reg(frp_pkg::REG_WHOLE, 32'd1000);
    send_tick(64'd5000);
    send_tick(64'd100);
    send_tick(64'h5555_5555_5555_5555);
    send_tick(64'hAAAA_AAAA_AAAA_AAAA);
    settle();

    // Gated mode with a 10 ms period: ticks before the deadline, one on it,
    // one inside two periods, one well past it (dropped), one exactly two
    // periods late (kept) and one just beyond that (dropped).
    write_reg(frp_pkg::REG_LINKED, 32'd0);
    write_reg(frp_pkg::REG_WHOLE, 32'd10);
    write_reg(frp_pkg::REG_FRAC, 32'd0);
    send_tick(64'd1000);
    send_tick(64'd1005);
    send_tick(64'd1010);
    send_tick(64'd1025);
    send_tick(64'd1100);
    send_tick(64'd1060);
    send_tick(64'd1071);
    settle();

    // A frame rate of zero keeps the window empty.
    write_reg(frp_pkg::REG_FPS, 32'd0);
    write_reg(frp_pkg::REG_LINKED, 32'd1);
    send_tick(64'd10);
    send_tick(64'd20);
    send_tick(64'd30);
    settle();

    // A full window of long, often saturated intervals drives the window sum close to its largest value.
    in_idle  = IDLE_NONE;
    out_idle = IDLE_NONE;
    write_reg(frp_pkg::REG_FPS, 32'd255);
    write_reg(frp_pkg::REG_LINKED, 32'd1);
    clock_ms = 64'd0;
    run_ticks(TICK_SLOW, 270);

    // Random phases: fresh settings each time, written only once drained.
    while (ticks_sent < 1620) begin
      settle();
      write_random_config(1'b0);
      in_idle  = idle_style_t'($urandom_range(0, 2));
      out_idle = idle_style_t'($urandom_range(0, 2));
      case ($urandom_range(0, 7))
        0:       clock_ms = {$urandom, $urandom};
        1:       clock_ms = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 3000);
        default: ;
      endcase
      sel = $urandom_range(0, 19);
      if (sel < 8) style = TICK_STEADY;
      else if (sel < 13) style = TICK_JITTER;
      else if (sel < 15) style = TICK_BURST;
      else if (sel < 16) style = TICK_SLOW;
      else style = TICK_NOISE;
      run_ticks(style, $urandom_range(10, 80));
    end

    // Drain with a bound, then keep watching so that any stray result shows.
    in_valid <= 1'b0;
    for (int w = 0; w < 2000 && pace.owed_results.size() != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pace.owed_results.size() != 0)
      pace.flag($sformatf("%0d results never arrived", pace.owed_results.size()));

    $display("Run covered %0d time samples and %0d register writes; %0d results checked.",
             ticks_sent, pace.writes, pace.checked);
    $display("Frames %0d, linked-mode skips %0d, late drops in gated mode %0d.",
             pace.frames, pace.skips, pace.drops);
    if (pace.mismatches == 0) begin
      $display("PASS frame_rate_pacer");
    end else begin
      $display("FAIL frame_rate_pacer");
    end
    $finish;
  end

endmodule
